// ===== sv/i2cmts_pkg.sv =====
// Package for the I2C master transaction sequencer.
// Holds item structs, sequencer phase, action, mode and outcome codes and
// the bus status codes. No dependencies.
`timescale 1ns / 1ps

package i2cmts_pkg;

  // Bus engine status codes (upper five bits of the status byte)
  localparam logic [7:0] StMask       = 8'hF8;
  localparam logic [7:0] StStart      = 8'h08;
  localparam logic [7:0] StRstart     = 8'h10;
  localparam logic [7:0] StMtSlaAck   = 8'h18;
  localparam logic [7:0] StMtDataAck  = 8'h28;
  localparam logic [7:0] StMrSlaAck   = 8'h40;
  localparam logic [7:0] StMrDataAck  = 8'h50;
  localparam logic [7:0] StMrDataNak  = 8'h58;

  typedef enum logic [0:0] {
    OP_BEGIN  = 1'b0,
    OP_REPORT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    MODE_WRITE     = 2'd0,
    MODE_REG_WRITE = 2'd1,
    MODE_READ      = 2'd2,
    MODE_REG_READ  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_SEND  = 3'd2,
    ACT_RACK  = 3'd3,
    ACT_RNACK = 3'd4,
    ACT_STOP  = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    OUT_RUN  = 2'd0,
    OUT_PASS = 2'd1,
    OUT_FAIL = 2'd2
  } outcome_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START   = 4'd1,
    PH_SLA_W   = 4'd2,
    PH_REG     = 4'd3,
    PH_DATA    = 4'd4,
    PH_RSTART  = 4'd5,
    PH_SLA_R   = 4'd6,
    PH_RD_ACK  = 4'd7,
    PH_RD_NACK = 4'd8
  } phase_e;

  typedef struct packed {
    logic       operation;
    logic [1:0] mode;
    logic [6:0] target_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic [7:0] bus_status;
    logic [7:0] received_byte;
    logic [7:0] next_write_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] send_value;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       finished;
    logic [1:0] outcome;
  } out_item_t;

endpackage

// ===== sv/i2c_master_transaction_sequencer.sv =====
// I2C master transaction sequencer: each result item is registered.
// Throughput: one item per cycle while the consumer takes results; the phase register
// and the result register are updated in the same cycle an item is accepted.
// A waiting result does not block input while the consumer takes it in that cycle.
// Reset (async, active low) returns the phase to idle, clears saved target, register,
// mode and byte count, and empties the result register. Depends on i2cmts_pkg.
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer
  import i2cmts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  phase_e     phase_q, phase_d;
  logic [1:0] mode_q, mode_d;
  logic [6:0] target_q, target_d;
  logic [7:0] register_q, register_d;
  logic [7:0] bytes_q, bytes_d;

  logic       out_valid_q;
  out_item_t  out_item_q, res;

  logic       accept;
  logic       is_begin;
  logic       begin_rd_empty;
  logic [7:0] exp_status;
  logic       status_ok;
  logic       bytes_nz;
  logic       bytes_gt1;
  logic [7:0] bytes_dec;
  logic [7:0] addr_w;
  logic [7:0] addr_r;

  // Handshake: take a new item whenever the result register frees up
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Decode helpers
  assign is_begin       = (in_item_i.operation == OP_BEGIN);
  assign begin_rd_empty = in_item_i.mode[1] && (in_item_i.byte_count == 8'd0);
  assign bytes_nz       = (bytes_q != 8'd0);
  assign bytes_gt1      = (bytes_q > 8'd1);
  assign bytes_dec      = bytes_q - 8'd1;
  assign addr_w         = {target_q, 1'b0};
  assign addr_r         = {target_q, 1'b1};
  assign status_ok      = ((in_item_i.bus_status & StMask) == exp_status);

  // Expected status for the action in flight
  always_comb begin
    case (phase_q)
      PH_START:  exp_status = StStart;
      PH_SLA_W:  exp_status = StMtSlaAck;
      PH_REG:    exp_status = StMtDataAck;
      PH_DATA:   exp_status = StMtDataAck;
      PH_RSTART: exp_status = StRstart;
      PH_SLA_R:  exp_status = StMrSlaAck;
      PH_RD_ACK: exp_status = StMrDataAck;
      default:   exp_status = StMrDataNak;
    endcase
  end

  // Next state
  always_comb begin
    phase_d    = phase_q;
    mode_d     = mode_q;
    target_d   = target_q;
    register_d = register_q;
    bytes_d    = bytes_q;
    if (is_begin) begin
      mode_d     = in_item_i.mode;
      target_d   = in_item_i.target_address;
      register_d = in_item_i.register_address;
      bytes_d    = in_item_i.byte_count;
      phase_d    = begin_rd_empty ? PH_IDLE : PH_START;
    end else if (!status_ok) begin
      phase_d = PH_IDLE;
    end else begin
      case (phase_q)
        PH_START: begin
          phase_d = (mode_q == MODE_READ) ? PH_SLA_R : PH_SLA_W;
        end
        PH_SLA_W, PH_REG, PH_DATA: begin
          if (phase_q == PH_SLA_W && mode_q != MODE_WRITE) begin
            phase_d = PH_REG;
          end else if (phase_q == PH_REG && mode_q == MODE_REG_READ) begin
            phase_d = PH_RSTART;
          end else if (bytes_nz) begin
            bytes_d = bytes_dec;
            phase_d = PH_DATA;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        PH_RSTART: begin
          phase_d = PH_SLA_R;
        end
        PH_SLA_R, PH_RD_ACK: begin
          phase_d = bytes_gt1 ? PH_RD_ACK : PH_RD_NACK;
          if (bytes_nz) begin
            bytes_d = bytes_dec;
          end
        end
        default: begin
          // Idle, last read or an unused code
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // Result item
  always_comb begin
    res = '0;
    if (is_begin) begin
      if (begin_rd_empty) begin
        res.finished = 1'b1;
        res.outcome  = OUT_FAIL;
      end else begin
        res.action = ACT_START;
      end
    end else if (phase_q == PH_IDLE || phase_q > PH_RD_NACK) begin
      res = '0;
    end else if (!status_ok) begin
      res.finished = 1'b1;
      res.outcome  = OUT_FAIL;
    end else begin
      case (phase_q)
        PH_START: begin
          res.action     = ACT_SEND;
          res.send_value = (mode_q == MODE_READ) ? addr_r : addr_w;
        end
        PH_SLA_W, PH_REG, PH_DATA: begin
          if (phase_q == PH_SLA_W && mode_q != MODE_WRITE) begin
            res.action     = ACT_SEND;
            res.send_value = register_q;
          end else if (phase_q == PH_REG && mode_q == MODE_REG_READ) begin
            res.action = ACT_START;
          end else if (bytes_nz) begin
            res.action     = ACT_SEND;
            res.send_value = in_item_i.next_write_byte;
          end else begin
            res.action   = ACT_STOP;
            res.finished = 1'b1;
            res.outcome  = OUT_PASS;
          end
        end
        PH_RSTART: begin
          res.action     = ACT_SEND;
          res.send_value = addr_r;
        end
        PH_SLA_R: begin
          res.action = bytes_gt1 ? ACT_RACK : ACT_RNACK;
        end
        PH_RD_ACK: begin
          res.action     = bytes_gt1 ? ACT_RACK : ACT_RNACK;
          res.read_byte  = in_item_i.received_byte;
          res.read_valid = 1'b1;
        end
        default: begin
          // Last read byte: deliver it and stop
          res.action     = ACT_STOP;
          res.read_byte  = in_item_i.received_byte;
          res.read_valid = 1'b1;
          res.finished   = 1'b1;
          res.outcome    = OUT_PASS;
        end
      endcase
    end
  end

  // Advance sequencer state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      mode_q     <= 2'd0;
      target_q   <= 7'd0;
      register_q <= 8'd0;
      bytes_q    <= 8'd0;
    end else if (accept) begin
      phase_q    <= phase_d;
      mode_q     <= mode_d;
      target_q   <= target_d;
      register_q <= register_d;
      bytes_q    <= bytes_d;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= res;
    end
  end

  // A result still in progress never carries a final outcome
  a_outcome_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.finished |-> out_item_o.outcome == OUT_RUN)
    else $error("unfinished result carries an outcome");

  // Read data only comes with a read request or the final stop
  a_read_action : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.read_valid |->
      (out_item_o.action == ACT_RACK || out_item_o.action == ACT_RNACK ||
       out_item_o.action == ACT_STOP))
    else $error("read data without a read action");

  // A zero-length read fails at once and leaves the sequencer idle
  a_empty_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_begin && begin_rd_empty |=>
      out_valid_o && out_item_o.outcome == OUT_FAIL && phase_q == PH_IDLE)
    else $error("zero-length read did not fail");

endmodule

// ===== tb/sequencer_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the I2C master transaction sequencer: watches both item
// channels, predicts each bus action and compares it with the block's output.
// Depends on i2cmts_pkg.

module sequencer_result_checker
  import i2cmts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        mismatch_cnt_o,
  output int        pending_cnt_o,
  output int        result_cnt_o,
  output int        read_cnt_o
);

  // Predicted sequencer state
  phase_e     seq_phase;
  mode_e      cur_mode;
  logic [6:0] cur_target;
  logic [7:0] cur_register;
  logic [7:0] bytes_left;

  out_item_t  expected_actions[$];
  out_item_t  want_item;
  logic       field_bad;

  // Issue the next write data byte, or stop once none remain
  function automatic out_item_t next_write(input logic [7:0] wbyte);
    out_item_t r;
    r = '0;
    if (bytes_left != 8'd0) begin
      bytes_left   = bytes_left - 8'd1;
      r.action     = ACT_SEND;
      r.send_value = wbyte;
      seq_phase    = PH_DATA;
    end else begin
      r.action   = ACT_STOP;
      r.finished = 1'b1;
      r.outcome  = OUT_PASS;
      seq_phase  = PH_IDLE;
    end
    return r;
  endfunction

  // Request the next read: ACK unless it is the last byte
  function automatic action_e next_read();
    action_e a;
    if (bytes_left > 8'd1) begin
      a         = ACT_RACK;
      seq_phase = PH_RD_ACK;
    end else begin
      a         = ACT_RNACK;
      seq_phase = PH_RD_NACK;
    end
    if (bytes_left != 8'd0) bytes_left = bytes_left - 8'd1;
    return a;
  endfunction

  // Advance the predicted state by one input item and return the bus action
  function automatic out_item_t predict_action(input in_item_t it);
    out_item_t  r;
    logic [7:0] want;
    r    = '0;
    want = StMrDataNak;
    if (it.operation == OP_BEGIN) begin
      cur_mode     = mode_e'(it.mode);
      cur_target   = it.target_address;
      cur_register = it.register_address;
      bytes_left   = it.byte_count;
      if ((cur_mode == MODE_READ || cur_mode == MODE_REG_READ) && bytes_left == 8'd0) begin
        r.finished = 1'b1;
        r.outcome  = OUT_FAIL;
        seq_phase  = PH_IDLE;
      end else begin
        r.action  = ACT_START;
        seq_phase = PH_START;
      end
    end else if (seq_phase != PH_IDLE) begin
      case (seq_phase)
        PH_START:        want = StStart;
        PH_SLA_W:        want = StMtSlaAck;
        PH_REG, PH_DATA: want = StMtDataAck;
        PH_RSTART:       want = StRstart;
        PH_SLA_R:        want = StMrSlaAck;
        PH_RD_ACK:       want = StMrDataAck;
        default:         want = StMrDataNak;
      endcase
      if ((it.bus_status & StMask) != want) begin
        // Drop the transaction without a stop
        r.finished = 1'b1;
        r.outcome  = OUT_FAIL;
        seq_phase  = PH_IDLE;
      end else begin
        case (seq_phase)
          PH_START: begin
            r.action = ACT_SEND;
            if (cur_mode == MODE_READ) begin
              r.send_value = {cur_target, 1'b1};
              seq_phase    = PH_SLA_R;
            end else begin
              r.send_value = {cur_target, 1'b0};
              seq_phase    = PH_SLA_W;
            end
          end
          PH_SLA_W: begin
            if (cur_mode == MODE_WRITE) begin
              r = next_write(it.next_write_byte);
            end else begin
              r.action     = ACT_SEND;
              r.send_value = cur_register;
              seq_phase    = PH_REG;
            end
          end
          PH_REG: begin
            if (cur_mode == MODE_REG_READ) begin
              r.action  = ACT_START;
              seq_phase = PH_RSTART;
            end else begin
              r = next_write(it.next_write_byte);
            end
          end
          PH_DATA: begin
            r = next_write(it.next_write_byte);
          end
          PH_RSTART: begin
            r.action     = ACT_SEND;
            r.send_value = {cur_target, 1'b1};
            seq_phase    = PH_SLA_R;
          end
          PH_SLA_R: begin
            r.action = next_read();
          end
          PH_RD_ACK: begin
            r.read_byte  = it.received_byte;
            r.read_valid = 1'b1;
            r.action     = next_read();
          end
          default: begin
            // Last byte arrives together with the stop
            r.action     = ACT_STOP;
            r.read_byte  = it.received_byte;
            r.read_valid = 1'b1;
            r.finished   = 1'b1;
            r.outcome    = OUT_PASS;
            seq_phase    = PH_IDLE;
          end
        endcase
      end
    end
    return r;
  endfunction

  // Compare accepted results first, then queue the prediction for a new item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_phase    = PH_IDLE;
      cur_mode     = MODE_WRITE;
      cur_target   = '0;
      cur_register = '0;
      bytes_left   = '0;
      expected_actions.delete();
      mismatch_cnt_o = 0;
      pending_cnt_o  = 0;
      result_cnt_o   = 0;
      read_cnt_o     = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        result_cnt_o++;
        if (out_item_i.read_valid === 1'b1) read_cnt_o++;
        if (expected_actions.size() == 0) begin
          mismatch_cnt_o++;
          if (mismatch_cnt_o <= 10)
            $display("%0t: result with nothing expected: act=%0d send=%02h rd=%02h rv=%0b fin=%0b out=%0d",
                     $time, out_item_i.action, out_item_i.send_value, out_item_i.read_byte,
                     out_item_i.read_valid, out_item_i.finished, out_item_i.outcome);
        end else begin
          want_item = expected_actions.pop_front();
          field_bad = (out_item_i.action     !== want_item.action)     ||
                      (out_item_i.send_value !== want_item.send_value) ||
                      (out_item_i.read_byte  !== want_item.read_byte)  ||
                      (out_item_i.read_valid !== want_item.read_valid) ||
                      (out_item_i.finished   !== want_item.finished)   ||
                      (out_item_i.outcome    !== want_item.outcome);
          if (field_bad) begin
            mismatch_cnt_o++;
            if (mismatch_cnt_o <= 10) begin
              $display("%0t: mismatch expected act=%0d send=%02h rd=%02h rv=%0b fin=%0b out=%0d",
                       $time, want_item.action, want_item.send_value, want_item.read_byte,
                       want_item.read_valid, want_item.finished, want_item.outcome);
              $display("%0t:          actual   act=%0d send=%02h rd=%02h rv=%0b fin=%0b out=%0d",
                       $time, out_item_i.action, out_item_i.send_value, out_item_i.read_byte,
                       out_item_i.read_valid, out_item_i.finished, out_item_i.outcome);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_actions.push_back(predict_action(in_item_i));
      pending_cnt_o = expected_actions.size();
    end
  end

endmodule

// ===== tb/i2c_master_transaction_sequencer_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the I2C master transaction sequencer: drives directed and
// random transactions with bursty input and a stalling receiver.
// Depends on i2cmts_pkg, the sequencer RTL and sequencer_result_checker.

module i2c_master_transaction_sequencer_tb;
  import i2cmts_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int ItemTarget = 1500;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  int mismatches;
  int pending;
  int results;
  int reads;

  int items_sent;
  int burst_left;
  int cycle_count;
  int mode_hits [4];
  int hold_left;
  int pat_mode;
  int pat_left;
  bit hold_done;

  int         pick;
  int         size_pick;
  mode_e      rnd_mode;
  logic [7:0] rnd_count;

  i2c_master_transaction_sequencer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  sequencer_result_checker checker_inst (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_item_i      (in_item),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_item_i     (out_item),
    .mismatch_cnt_o (mismatches),
    .pending_cnt_o  (pending),
    .result_cnt_o   (results),
    .read_cnt_o     (reads)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Fill every field with random bits
  function automatic in_item_t random_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  // Build a completion report carrying the given status code
  function automatic in_item_t status_report(input logic [7:0] code);
    in_item_t it;
    it            = random_item();
    it.operation  = OP_REPORT;
    it.bus_status = (code & StMask) | 8'($urandom_range(0, 7));
    return it;
  endfunction

  // Offer one item, hold it until accepted, then idle between bursts
  task automatic send_item(input in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
    end
  endtask

  // Begin a transaction and answer with the status codes it expects;
  // cut limits the reports sent, bad_at corrupts the status at that report
  task automatic run_transaction(input mode_e m, input logic [6:0] tgt, input logic [7:0] rg,
                                 input logic [7:0] n, input int cut, input int bad_at);
    in_item_t   it;
    int         total;
    int         k;
    logic [7:0] code;
    it                  = random_item();
    it.operation        = OP_BEGIN;
    it.mode             = m;
    it.target_address   = tgt;
    it.register_address = rg;
    it.byte_count       = n;
    mode_hits[m]++;
    send_item(it);
    case (m)
      MODE_WRITE:     total = 2 + n;
      MODE_REG_WRITE: total = 3 + n;
      MODE_READ:      total = (n == 0) ? 0 : n + 2;
      default:        total = (n == 0) ? 0 : n + 5;
    endcase
    if (cut >= 0 && cut < total) total = cut;
    for (k = 0; k < total; k++) begin
      case (m)
        MODE_WRITE, MODE_REG_WRITE: begin
          code = (k == 0) ? StStart : (k == 1) ? StMtSlaAck : StMtDataAck;
        end
        MODE_READ: begin
          code = (k == 0) ? StStart : (k == 1) ? StMrSlaAck :
                 (k == n + 1) ? StMrDataNak : StMrDataAck;
        end
        default: begin
          code = (k == 0) ? StStart : (k == 1) ? StMtSlaAck : (k == 2) ? StMtDataAck :
                 (k == 3) ? StRstart : (k == 4) ? StMrSlaAck :
                 (k == n + 4) ? StMrDataNak : StMrDataAck;
        end
      endcase
      it = status_report(code);
      if (k == bad_at) begin
        // Corrupt the status and end the stream here
        it.bus_status = 8'($urandom);
        if ((it.bus_status & StMask) == code) it.bus_status[7] = ~it.bus_status[7];
        total = k;
      end
      send_item(it);
    end
  endtask

  // Stimulus: reset, directed cases, then random transactions
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    items_sent = 0;
    burst_left = 4;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: field extremes, every mode, special cases
    run_transaction(MODE_WRITE, 7'h7F, 8'h00, 8'd1, -1, -1);
    run_transaction(MODE_REG_WRITE, 7'h00, 8'hFF, 8'd0, -1, -1);
    run_transaction(MODE_READ, 7'h05, 8'h00, 8'd0, -1, -1);
    run_transaction(MODE_REG_READ, 7'h2A, 8'h80, 8'd0, -1, -1);
    run_transaction(MODE_REG_READ, 7'h7F, 8'h3C, 8'd2, -1, -1);
    send_item(status_report(8'($urandom)));
    run_transaction(MODE_WRITE, 7'h11, 8'h22, 8'd3, -1, 0);
    run_transaction(MODE_REG_WRITE, 7'h33, 8'h44, 8'd2, 1, -1);
    run_transaction(MODE_READ, 7'h55, 8'h00, 8'd1, -1, -1);

    // Random: mostly well-formed transactions, some broken or abandoned
    while (items_sent < ItemTarget) begin
      pick      = $urandom_range(0, 99);
      size_pick = $urandom_range(0, 99);
      rnd_mode  = mode_e'($urandom_range(0, 3));
      if (size_pick < 85)      rnd_count = 8'($urandom_range(0, 4));
      else if (size_pick < 99) rnd_count = 8'($urandom_range(5, 24));
      else                     rnd_count = 8'($urandom_range(25, 255));
      if (pick < 70) begin
        run_transaction(rnd_mode, 7'($urandom), 8'($urandom), rnd_count, -1, -1);
      end else if (pick < 85) begin
        run_transaction(rnd_mode, 7'($urandom), 8'($urandom), rnd_count, -1,
                        $urandom_range(0, 6));
      end else if (pick < 95) begin
        run_transaction(rnd_mode, 7'($urandom), 8'($urandom), 8'($urandom), $urandom_range(0, 5),
                        -1);
      end else begin
        repeat ($urandom_range(1, 3)) send_item(random_item());
      end
    end
    if (in_valid) in_valid <= 1'b0;

    // Drain outstanding results, then allow the pipeline to settle
    while (pending != 0) @(negedge clk);
    repeat (5) @(negedge clk);

    $display("Sent %0d items over %0d transactions (write %0d, reg write %0d, read %0d, reg read %0d)",
             items_sent, mode_hits[0] + mode_hits[1] + mode_hits[2] + mode_hits[3],
             mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
    $display("Checked %0d results with %0d read bytes under bursty input and a long output stall",
             results, reads);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Receiver: random stall patterns plus one long hold-off mid-run
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    pat_mode  = 0;
    pat_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && items_sent >= 400) begin
        hold_done = 1'b1;
        hold_left = 250;
        out_ready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(0, 3);
          pat_left = $urandom_range(1, 64);
        end
        pat_left--;
        case (pat_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  // Watchdog: end the run if it takes far too long
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Regression FAIL");
    $finish;
  end

endmodule
